FILE: hw/rtl/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg: shared constants for the circle proximity pipeline
// Stage counts of the square root and divider pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package ccp_pkg;

  localparam int unsigned SqrtStages = 34;
  localparam int unsigned DivStages  = 31;

endpackage

`default_nettype wire

FILE: hw/rtl/circle_circle_proximity_unit.sv
// ----------------------------------------------------------------------------
// circle_circle_proximity_unit: distance and closest points of two circles
// Centre distance by pipelined square root, closest points by pipelined
// rounded division of radius times centre offset by the distance.
// ----------------------------------------------------------------------------
//  channel | handshake                      | payload
//  in      | in_valid_i / in_ready_o        | two centres and two radii
//  out     | out_valid_o / out_ready_i      | separation, near points, flag
//
// One word per cycle unless stalled: 71 register stages, of which 34
// square root stages and 31 divider stages set the depth. The whole pipeline
// advances when the output register is empty or taken; a stall holds every
// stage. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_circle_proximity_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] first_center_x_i,
  input  wire logic signed [31:0] first_center_y_i,
  input  wire logic        [30:0] first_radius_i,
  input  wire logic signed [31:0] second_center_x_i,
  input  wire logic signed [31:0] second_center_y_i,
  input  wire logic        [30:0] second_radius_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed      [35:0] separation_o,
  output logic signed      [33:0] near_point_first_x_o,
  output logic signed      [33:0] near_point_first_y_o,
  output logic signed      [33:0] near_point_second_x_o,
  output logic signed      [33:0] near_point_second_y_o,
  output logic                    coincident_o
);
  import ccp_pkg::*;

  localparam int unsigned RootIdx = 2 + SqrtStages;
  localparam int unsigned NumSt   = RootIdx + 4 + DivStages;
  localparam int unsigned SideLen = NumSt - 1;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic [30:0]        r1;
    logic [30:0]        r2;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic               sgx;
    logic               sgy;
    logic               same;
  } side_t;

  logic        v_q [NumSt];
  side_t       side_q [SideLen];
  side_t       side_d;
  logic        en;
  logic signed [32:0] dx, dy;

  assign en          = !v_q[NumSt-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NumSt-1];

  assign dx = 33'(second_center_x_i) - 33'(first_center_x_i);
  assign dy = 33'(second_center_y_i) - 33'(first_center_y_i);

  always_comb begin
    side_d.x1   = first_center_x_i;
    side_d.y1   = first_center_y_i;
    side_d.x2   = second_center_x_i;
    side_d.y2   = second_center_y_i;
    side_d.r1   = first_radius_i;
    side_d.r2   = second_radius_i;
    side_d.sgx  = dx[32];
    side_d.sgy  = dy[32];
    side_d.ax   = dx[32] ? 33'(-dx) : dx;
    side_d.ay   = dy[32] ? 33'(-dy) : dy;
    side_d.same = (dx == '0) && (dy == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumSt; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k < NumSt; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < SideLen; k++) side_q[k] <= side_q[k-1];
    end
  end

  // squares and sum
  logic [64:0] sqx_q, sqy_q;
  logic [65:0] sum_q;
  logic [33:0] root;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= 65'(side_q[0].ax * side_q[0].ax);
      sqy_q <= 65'(side_q[0].ay * side_q[0].ay);
      sum_q <= 66'(sqx_q) + 66'(sqy_q);
    end
  end

  ccp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum_q),
    .root_o (root)
  );

  // products, separation, rounding offset
  logic [63:0] pr1x_q, pr1y_q, pr2x_q, pr2y_q;
  logic [33:0] dist_q, den_q;
  logic [63:0] num_q [4];
  logic [35:0] sep_q [DivStages + 2];
  side_t       sr;

  assign sr = side_q[RootIdx];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr1x_q   <= 64'(sr.r1 * sr.ax);
      pr1y_q   <= 64'(sr.r1 * sr.ay);
      pr2x_q   <= 64'(sr.r2 * sr.ax);
      pr2y_q   <= 64'(sr.r2 * sr.ay);
      dist_q   <= root;
      sep_q[0] <= 36'(root) - 36'(sr.r1) - 36'(sr.r2);
      num_q[0] <= pr1x_q + 64'(dist_q[33:1]);
      num_q[1] <= pr1y_q + 64'(dist_q[33:1]);
      num_q[2] <= pr2x_q + 64'(dist_q[33:1]);
      num_q[3] <= pr2y_q + 64'(dist_q[33:1]);
      den_q    <= dist_q;
      for (int k = 1; k < DivStages + 2; k++) sep_q[k] <= sep_q[k-1];
    end
  end

  logic [30:0] quo [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    ccp_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[l]),
      .den_i (den_q),
      .quo_o (quo[l])
    );
  end

  // apply offsets
  side_t fs;
  logic signed [33:0] o1x, o1y, o2x, o2y;
  logic signed [33:0] p1x_d, p1y_d, p2x_d, p2y_d;

  assign fs  = side_q[SideLen-1];
  assign o1x = fs.sgx ? -34'(quo[0]) : 34'(quo[0]);
  assign o1y = fs.sgy ? -34'(quo[1]) : 34'(quo[1]);
  assign o2x = fs.sgx ? -34'(quo[2]) : 34'(quo[2]);
  assign o2y = fs.sgy ? -34'(quo[3]) : 34'(quo[3]);

  always_comb begin
    p1x_d = 34'(fs.x1);
    p1y_d = 34'(fs.y1);
    p2x_d = 34'(fs.x2);
    p2y_d = 34'(fs.y2);
    if (!fs.same) begin
      p1x_d = 34'(fs.x1) + o1x;
      p1y_d = 34'(fs.y1) + o1y;
      p2x_d = 34'(fs.x2) - o2x;
      p2y_d = 34'(fs.y2) - o2y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      separation_o          <= sep_q[DivStages + 1];
      near_point_first_x_o  <= p1x_d;
      near_point_first_y_o  <= p1y_d;
      near_point_second_x_o <= p2x_d;
      near_point_second_y_o <= p2y_d;
      coincident_o          <= fs.same;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ccp_isqrt.sv
// ----------------------------------------------------------------------------
// ccp_isqrt: pipelined integer square root
// floor(sqrt) of a 66-bit radicand, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_isqrt (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [65:0] rad_i,
  output logic      [33:0] root_o
);
  import ccp_pkg::*;

  logic [35:0] rem_q  [SqrtStages];
  logic [33:0] root_q [SqrtStages];
  logic [67:0] rad_q  [SqrtStages];

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
    logic [35:0] rem_in;
    logic [33:0] root_in;
    logic [67:0] rad_in;
    logic [37:0] rem_sh;
    logic [37:0] trial;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = {2'b00, rad_i};
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end
    assign rem_sh = {rem_in, rad_in[67:66]};
    assign trial  = {2'b00, root_in, 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k] <= {rad_in[65:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q[k]  <= 36'(rem_sh - trial);
          root_q[k] <= {root_in[32:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh[35:0];
          root_q[k] <= {root_in[32:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[SqrtStages-1];

endmodule

`default_nettype wire

FILE: hw/rtl/ccp_div.sv
// ----------------------------------------------------------------------------
// ccp_div: pipelined restoring divider
// 64-bit numerator over 34-bit divisor, quotient known to fit 31 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_div (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] num_i,
  input  wire logic [33:0] den_i,
  output logic      [30:0] quo_o
);
  import ccp_pkg::*;

  logic [33:0] p_q [DivStages];
  logic [30:0] n_q [DivStages];
  logic [30:0] q_q [DivStages];
  logic [33:0] d_q [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [33:0] p_in;
    logic [30:0] n_in;
    logic [30:0] q_in;
    logic [33:0] d_in;
    logic [34:0] t;
    if (k == 0) begin : g_first
      assign p_in = {1'b0, num_i[63:31]};
      assign n_in = num_i[30:0];
      assign q_in = '0;
      assign d_in = den_i;
    end else begin : g_next
      assign p_in = p_q[k-1];
      assign n_in = n_q[k-1];
      assign q_in = q_q[k-1];
      assign d_in = d_q[k-1];
    end
    assign t = {p_in, n_in[30]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k] <= {n_in[29:0], 1'b0};
        d_q[k] <= d_in;
        if (t >= {1'b0, d_in}) begin
          p_q[k] <= 34'(t - {1'b0, d_in});
          q_q[k] <= {q_in[29:0], 1'b1};
        end else begin
          p_q[k] <= t[33:0];
          q_q[k] <= {q_in[29:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = q_q[DivStages-1];

endmodule

`default_nettype wire
